FILE: sv/ipv4p_pkg.sv
package ipv4p_pkg;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_ZERO  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_OCT = 2'd1;
  localparam logic [1:0] RX_HEX = 2'd2;

  localparam logic [4:0] NO_DIGIT = 5'd16;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  localparam logic [1:0] LAST_PART_INDEX = 2'd3;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_char;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic        parse_ok;
    logic [31:0] address;
  } out_item_t;

  typedef struct packed {
    logic [1:0]      phase;
    logic [1:0]      radix;
    logic            digit_seen;
    logic [31:0]     part_value;
    logic [1:0]      part_index;
    logic [2:0][7:0] earlier_parts;
    logic            failed;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase:         PH_START,
    radix:         RX_DEC,
    digit_seen:    1'b0,
    part_value:    32'd0,
    part_index:    2'd0,
    earlier_parts: '0,
    failed:        1'b0
  };

  // digit value of c in radix rx, NO_DIGIT when c is not a digit there
  function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] rx);
    logic [4:0] d;
    d = NO_DIGIT;
    if (rx == RX_OCT) begin
      if (c inside {[8'h30:8'h37]}) d = 5'(c - 8'h30);
    end else begin
      if (c inside {[8'h30:8'h39]}) begin
        d = 5'(c - 8'h30);
      end else if (rx == RX_HEX) begin
        if (c inside {[8'h61:8'h66]}) d = 5'(c - 8'h61 + 8'd10);
        else if (c inside {[8'h41:8'h46]}) d = 5'(c - 8'h41 + 8'd10);
      end
    end
    return d;
  endfunction

endpackage

FILE: sv/ipv4p_step.sv
module ipv4p_step (
  input  ipv4p_pkg::in_item_t     item_i,
  input  ipv4p_pkg::parse_state_t cur_i,
  output ipv4p_pkg::parse_state_t nxt_o,
  output logic                    res_valid_o,
  output ipv4p_pkg::out_item_t    res_o
);

  ipv4p_pkg::parse_state_t st;
  logic        go_digits;
  logic [4:0]  dig;
  logic [35:0] prod;
  logic [36:0] sum;
  logic        ok;
  logic [31:0] addr;

  always_comb begin
    st        = cur_i;
    go_digits = 1'b0;
    dig       = ipv4p_pkg::NO_DIGIT;
    prod      = '0;
    sum       = '0;
    ok        = 1'b0;
    addr      = '0;

    if (item_i.has_char && !cur_i.failed) begin
      if (item_i.char_byte == ipv4p_pkg::CH_COLON) begin
        st.failed = 1'b1;
      end else begin
        case (cur_i.phase)
          ipv4p_pkg::PH_START: begin
            st.part_value = '0;
            if (item_i.char_byte == ipv4p_pkg::CH_ZERO) begin
              st.phase      = ipv4p_pkg::PH_ZERO;
              st.radix      = ipv4p_pkg::RX_OCT;
              st.digit_seen = 1'b1;
            end else begin
              st.phase      = ipv4p_pkg::PH_DIGIT;
              st.radix      = ipv4p_pkg::RX_DEC;
              st.digit_seen = 1'b0;
              go_digits     = 1'b1;
            end
          end
          ipv4p_pkg::PH_ZERO: begin
            st.phase = ipv4p_pkg::PH_DIGIT;
            if (item_i.char_byte == ipv4p_pkg::CH_LO_X ||
                item_i.char_byte == ipv4p_pkg::CH_UP_X) begin
              st.radix      = ipv4p_pkg::RX_HEX;
              st.digit_seen = 1'b0;
            end else begin
              go_digits = 1'b1;
            end
          end
          default: begin
            go_digits = 1'b1;
          end
        endcase
      end
    end

    if (go_digits) begin
      dig = ipv4p_pkg::digit_of(item_i.char_byte, st.radix);
      // times 8 or 16 as a shift, times 10 as shifts and one add
      case (st.radix)
        ipv4p_pkg::RX_HEX: prod = {st.part_value, 4'b0000};
        ipv4p_pkg::RX_OCT: prod = {1'b0, st.part_value, 3'b000};
        default:           prod = {1'b0, st.part_value, 3'b000} +
                                  {3'b000, st.part_value, 1'b0};
      endcase
      sum = {1'b0, prod} + {32'd0, dig};
      if (dig != ipv4p_pkg::NO_DIGIT) begin
        if (sum[36:32] != 5'd0) begin
          st.failed = 1'b1;
        end else begin
          st.part_value = sum[31:0];
          st.digit_seen = 1'b1;
        end
      end else if (item_i.char_byte == ipv4p_pkg::CH_DOT && st.digit_seen &&
                   st.part_index != ipv4p_pkg::LAST_PART_INDEX &&
                   st.part_value[31:8] == 24'd0) begin
        st.earlier_parts[st.part_index] = st.part_value[7:0];
        st.part_index = st.part_index + 2'd1;
        st.phase      = ipv4p_pkg::PH_START;
        st.radix      = ipv4p_pkg::RX_DEC;
        st.digit_seen = 1'b0;
        st.part_value = '0;
      end else begin
        st.failed = 1'b1;
      end
    end

    if (item_i.is_last) begin
      ok = !st.failed && st.phase != ipv4p_pkg::PH_START && st.digit_seen;
      // the last part fills whatever bytes the earlier parts left
      case (st.part_index)
        2'd0: begin
          addr = st.part_value;
        end
        2'd1: begin
          ok   = ok && st.part_value[31:24] == 8'd0;
          addr = {st.earlier_parts[0], st.part_value[23:0]};
        end
        2'd2: begin
          ok   = ok && st.part_value[31:16] == 16'd0;
          addr = {st.earlier_parts[0], st.earlier_parts[1], st.part_value[15:0]};
        end
        default: begin
          ok   = ok && st.part_value[31:8] == 24'd0;
          addr = {st.earlier_parts[0], st.earlier_parts[1], st.earlier_parts[2],
                  st.part_value[7:0]};
        end
      endcase
      if (!ok) addr = '0;
    end

    nxt_o          = item_i.is_last ? ipv4p_pkg::STATE_CLEAR : st;
    res_valid_o    = item_i.is_last;
    res_o.parse_ok = ok;
    res_o.address  = addr;
  end

endmodule

FILE: sv/ipv4p_out_reg.sv
module ipv4p_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  ipv4p_pkg::out_item_t res_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ipv4p_pkg::out_item_t out_item_o
);

  logic                 valid_q, valid_d;
  ipv4p_pkg::out_item_t item_q;

  assign ready_o     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (!out_stall_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) item_q <= res_i;
  end

endmodule

FILE: sv/ipv4_text_address_parser_unit.sv
// Streaming IPv4 text address parser: one character item per clock, with is_last
// on the final item, producing a single result (parse_ok and the 32-bit address,
// 0 on failure) for every string. Accepts legacy forms of one to four dot-separated
// parts in decimal, octal (leading 0) or hex (0x/0X). Sustained rate is one item
// per cycle while the input is not stalled; a result is offered from the result
// register, as each item is parsed out of the input register straight into the
// result register. The per-character shift-add and range compares lie between
// the input register and the parser state. The input stalls only when a result
// must be written while the result register is held.
module ipv4_text_address_parser_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ipv4p_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ipv4p_pkg::out_item_t out_item_o
);

  logic                    in_valid_q, in_valid_d;
  ipv4p_pkg::in_item_t     in_item_q;
  ipv4p_pkg::parse_state_t state_q, state_d;
  logic                    res_valid;
  ipv4p_pkg::out_item_t    res;
  logic                    out_ready;
  logic                    fire;
  logic                    in_load;

  ipv4p_step u_step (
    .item_i      (in_item_q),
    .cur_i       (state_q),
    .nxt_o       (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // held item moves on unless its result has nowhere to go
  assign fire       = in_valid_q && (!res_valid || out_ready);
  assign in_load    = !in_valid_q || fire;
  assign in_stall_o = !in_load;
  assign in_valid_d = in_load ? in_valid_i : in_valid_q;

  ipv4p_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= ipv4p_pkg::STATE_CLEAR;
    end else begin
      in_valid_q <= in_valid_d;
      if (fire) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) in_item_q <= in_item_i;
  end

endmodule
